// File: hdl/fcs_pkg.sv
// Shared definitions for the fixed-capacity byte sequence store.
// Holds field widths, the operation codes, the sequencer states and the result record.
// Depends on nothing; fcs_ctrl, the top level and the testbench import it.
package fcs_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int OP_W    = 3;
  localparam int INDEX_W = 7;
  localparam int VALUE_W = 8;
  localparam int LEN_W   = 7;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR    = 3'd0,
    OP_APPEND   = 3'd1,
    OP_READ     = 3'd2,
    OP_MODIFY   = 3'd3,
    OP_DELETE   = 3'd4,
    OP_INSERT   = 3'd5,
    OP_EMIT_PRE = 3'd6,
    OP_EMIT_SUF = 3'd7
  } fcs_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_MOVE,
    ST_FLUSH,
    ST_PUT,
    ST_RESP,
    ST_EMIT
  } fcs_state_t;

  typedef struct packed {
    logic [VALUE_W-1:0] data;
    logic [LEN_W-1:0]   length;
    logic               accepted;
    logic               empty_result;
    logic               last;
  } fcs_result_t;

endpackage

// File: hdl/fcs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// The read data holds its value while no read is issued.
// Depends on nothing.
module fcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/fcs_ctrl.sv
// Sequencer of the byte sequence store: decodes a request, walks the element RAM
// for shifts and streams, and holds the result in an output register.
// Depends on fcs_pkg; drives one fcs_ram instance in the top level.
module fcs_ctrl
  import fcs_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fcs_op_t                     in_op,
  input  logic [INDEX_W-1:0]          in_index,
  input  logic [VALUE_W-1:0]          in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fcs_result_t                 out_result,
  output logic                        ram_we,
  output logic [$clog2(CAPACITY)-1:0] ram_waddr,
  output logic [VALUE_W-1:0]          ram_wdata,
  output logic                        ram_re,
  output logic [$clog2(CAPACITY)-1:0] ram_raddr,
  input  logic [VALUE_W-1:0]          ram_rdata
);

  localparam int AW = $clog2(CAPACITY);

  fcs_state_t         state_r, state_nxt;
  fcs_op_t            op_r, op_nxt;
  logic [INDEX_W-1:0] idx_r, idx_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [LEN_W-1:0]   count_r, count_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [AW-1:0]      end_r, end_nxt;
  logic [AW-1:0]      pend_addr_r, pend_addr_nxt;
  logic               pend_r, pend_nxt;
  logic               acc_r, acc_nxt;
  logic               empty_r, empty_nxt;
  logic               out_valid_r, out_valid_nxt;
  fcs_result_t        out_r, out_nxt;

  logic               accept;
  logic               slot_free;
  logic               full;
  logic               idx_lt_n;
  logic               idx_le_n;
  logic               idx_is_last;
  logic               ins_ok;
  logic               shift_left;
  logic [LEN_W-1:0]   n_m1;
  logic [INDEX_W-1:0] idx_m1;
  logic [INDEX_W-1:0] idx_p1;

  assign in_ready    = (state_r == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign slot_free   = !out_valid_r || out_ready;
  assign full        = (count_r == LEN_W'(CAPACITY));
  assign idx_lt_n    = (idx_r < count_r);
  assign idx_le_n    = (idx_r <= count_r);
  assign n_m1        = count_r - 1'b1;
  assign idx_m1      = idx_r - 1'b1;
  assign idx_p1      = idx_r + 1'b1;
  assign idx_is_last = (idx_r == n_m1);
  assign ins_ok      = !full && idx_lt_n;
  assign shift_left  = (op_r == OP_DELETE);

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_START;
      end
      ST_START: begin
        case (op_r)
          OP_DELETE:   state_nxt = (idx_lt_n && !idx_is_last) ? ST_MOVE : ST_RESP;
          OP_INSERT:   state_nxt = ins_ok ? ST_MOVE : ST_RESP;
          OP_EMIT_PRE: state_nxt = (idx_le_n && idx_r != '0) ? ST_EMIT : ST_RESP;
          OP_EMIT_SUF: state_nxt = (idx_lt_n && !idx_is_last) ? ST_EMIT : ST_RESP;
          default:     state_nxt = ST_RESP;
        endcase
      end
      ST_MOVE: begin
        if (ptr_r == end_r) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_nxt = (op_r == OP_INSERT) ? ST_PUT : ST_RESP;
      end
      ST_PUT: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      ST_EMIT: begin
        if (slot_free && ptr_r == end_r) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath, RAM control and the output register.
  always_comb begin
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    end_nxt       = end_r;
    pend_addr_nxt = pend_addr_r;
    pend_nxt      = (state_r == ST_MOVE);
    acc_nxt       = acc_r;
    empty_nxt     = empty_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = pend_addr_r;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = ptr_r;

    // A shifted element arrives in the cycle after its read and is written back here.
    if (pend_r) begin
      ram_we = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt  = in_op;
          idx_nxt = in_index;
          val_nxt = in_value;
        end
      end
      ST_START: begin
        empty_nxt = 1'b0;
        case (op_r)
          OP_CLEAR: begin
            count_nxt = '0;
            acc_nxt   = 1'b1;
          end
          OP_APPEND: begin
            acc_nxt = !full;
            if (!full) begin
              ram_we    = 1'b1;
              ram_waddr = count_r[AW-1:0];
              ram_wdata = val_r;
              count_nxt = count_r + 1'b1;
            end
          end
          OP_READ: begin
            acc_nxt   = idx_lt_n;
            ram_re    = 1'b1;
            ram_raddr = idx_r[AW-1:0];
          end
          OP_MODIFY: begin
            acc_nxt = idx_lt_n;
            if (idx_lt_n) begin
              ram_we    = 1'b1;
              ram_waddr = idx_r[AW-1:0];
              ram_wdata = val_r;
            end
          end
          OP_DELETE: begin
            acc_nxt = idx_lt_n;
            ptr_nxt = idx_p1[AW-1:0];
            end_nxt = n_m1[AW-1:0];
            if (idx_lt_n) count_nxt = n_m1;
          end
          OP_INSERT: begin
            acc_nxt = ins_ok;
            ptr_nxt = n_m1[AW-1:0];
            end_nxt = idx_r[AW-1:0];
            if (ins_ok) count_nxt = count_r + 1'b1;
          end
          OP_EMIT_PRE: begin
            acc_nxt   = idx_le_n;
            empty_nxt = 1'b1;
            ram_re    = 1'b1;
            ram_raddr = '0;
            ptr_nxt   = '0;
            end_nxt   = idx_m1[AW-1:0];
          end
          OP_EMIT_SUF: begin
            acc_nxt   = idx_lt_n;
            empty_nxt = 1'b1;
            ram_re    = 1'b1;
            ram_raddr = idx_p1[AW-1:0];
            ptr_nxt   = idx_p1[AW-1:0];
            end_nxt   = n_m1[AW-1:0];
          end
          default: begin
            acc_nxt = 1'b0;
          end
        endcase
      end
      ST_MOVE: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_r;
        if (shift_left) begin
          pend_addr_nxt = ptr_r - 1'b1;
          ptr_nxt       = ptr_r + 1'b1;
        end else begin
          pend_addr_nxt = ptr_r + 1'b1;
          ptr_nxt       = ptr_r - 1'b1;
        end
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = val_r;
      end
      ST_RESP: begin
        if (slot_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.data         = (op_r == OP_READ && acc_r) ? ram_rdata : '0;
          out_nxt.length       = count_r;
          out_nxt.accepted     = acc_r;
          out_nxt.empty_result = empty_r;
          out_nxt.last         = 1'b1;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.data         = ram_rdata;
          out_nxt.length       = count_r;
          out_nxt.accepted     = 1'b1;
          out_nxt.empty_result = 1'b0;
          out_nxt.last         = (ptr_r == end_r);
          if (ptr_r != end_r) begin
            ram_re    = 1'b1;
            ram_raddr = ptr_r + 1'b1;
            ptr_nxt   = ptr_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    val_r       <= val_nxt;
    ptr_r       <= ptr_nxt;
    end_r       <= end_nxt;
    pend_addr_r <= pend_addr_nxt;
    acc_r       <= acc_nxt;
    empty_r     <= empty_nxt;
    out_r       <= out_nxt;
  end

endmodule

// File: hdl/fixed_capacity_char_sequence_top.sv
// Fixed-capacity byte sequence store, top level. Depends on fcs_pkg, fcs_ram, fcs_ctrl.
// A simple request passes the START and RESP states; a delete adds the shift walk (MOVE,
// FLUSH) and an insert adds the walk and PUT. A new request is taken only in the idle state.
// Emits stream one element per cycle while the receiver is ready.
// Reset (synchronous, rst_n low) clears the element count and the handshake state; the
// element RAM is not cleared, since no entry is read before it has been written.
module fixed_capacity_char_sequence_top
  import fcs_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // op [2:0], index [9:3], value [17:10], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // data [7:0], length [14:8], zero fill
  output logic [1:0]  out_tuser,  // accepted [0], empty_result [1]
  output logic        out_tlast
);

  localparam int AW = $clog2(CAPACITY);

  fcs_result_t        result;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  // The sequencer owns all control state and the output register, so a
  // result may wait on the master side while the next request is taken.
  fcs_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (fcs_op_t'(in_tdata[2:0])),
    .in_index   (in_tdata[9:3]),
    .in_value   (in_tdata[17:10]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // Element storage: one entry per position of the sequence.
  fcs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tdata = {1'b0, result.length, result.data};
  assign out_tuser = {result.empty_result, result.accepted};
  assign out_tlast = result.last;

endmodule

// File: tb/fixed_capacity_char_sequence_top_tb.sv
// Testbench for fixed_capacity_char_sequence_top, the 64-entry byte sequence store.
// It runs a directed list of requests and then random ones, and checks every result against
// a behavioral model of the sequence or a hand-written result. Depends on fcs_pkg and the RTL top.
module fixed_capacity_char_sequence_top_tb;
  import fcs_pkg::*;

  localparam int SEQ_CAP      = CAPACITY_DEF;
  localparam int QUIET_LIMIT  = 3000;  // cycles without any handshake before giving up
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off used to back up the block
  localparam int SETTLE       = 80;    // covers a full-length shift walk after the last result
  localparam int N_DIRECTED   = 22;

  // One row of the directed list. Rows with typed set carry their single result
  // written out by hand; the others take their results from the sequence model.
  typedef struct {
    fcs_op_t     op;
    logic [6:0]  idx;
    logic [7:0]  val;
    bit          typed;
    fcs_result_t want;
  } seq_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // op [2:0], index [9:3], value [17:10], zero fill
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // data [7:0], length [14:8], zero fill
  logic [1:0]  out_tuser;  // accepted [0], empty_result [1]
  logic        out_tlast;

  // Behavioral copy of the sequence and the results it still owes.
  logic [7:0]  seq_mem [SEQ_CAP];
  int          seq_count;
  fcs_result_t seq_replies_due [$];

  int send_idle_pct;
  int recv_idle_pct;
  bit stall_req;
  int mismatches;
  int quiet_cycles;
  int requests_sent;
  int results_seen;
  int refused_seen;
  int full_hits;
  int max_stream;

  seq_row_t stim_rows [N_DIRECTED] = '{
    // Everything refused or empty while the store holds nothing.
    '{OP_READ,     7'd0,   8'h00, 1'b1, '{8'h00, 7'd0, 1'b0, 1'b0, 1'b1}},
    '{OP_EMIT_PRE, 7'd0,   8'h00, 1'b1, '{8'h00, 7'd0, 1'b1, 1'b1, 1'b1}},
    '{OP_EMIT_SUF, 7'd0,   8'h00, 1'b1, '{8'h00, 7'd0, 1'b0, 1'b1, 1'b1}},
    '{OP_DELETE,   7'd0,   8'h00, 1'b1, '{8'h00, 7'd0, 1'b0, 1'b0, 1'b1}},
    '{OP_INSERT,   7'd0,   8'h11, 1'b1, '{8'h00, 7'd0, 1'b0, 1'b0, 1'b1}},
    '{OP_MODIFY,   7'd0,   8'h22, 1'b1, '{8'h00, 7'd0, 1'b0, 1'b0, 1'b1}},
    // Extreme byte values, then an insert at the position equal to the count.
    '{OP_APPEND,   7'd0,   8'h00, 1'b1, '{8'h00, 7'd1, 1'b1, 1'b0, 1'b1}},
    '{OP_APPEND,   7'd127, 8'hFF, 1'b1, '{8'h00, 7'd2, 1'b1, 1'b0, 1'b1}},
    '{OP_INSERT,   7'd2,   8'h55, 1'b1, '{8'h00, 7'd2, 1'b0, 1'b0, 1'b1}},
    '{OP_INSERT,   7'd0,   8'hAA, 1'b0, '0},
    '{OP_MODIFY,   7'd1,   8'h5A, 1'b0, '0},
    '{OP_READ,     7'd1,   8'h00, 1'b0, '0},
    '{OP_EMIT_PRE, 7'd3,   8'h00, 1'b0, '0},
    '{OP_EMIT_SUF, 7'd2,   8'h00, 1'b0, '0},
    '{OP_EMIT_SUF, 7'd0,   8'h00, 1'b0, '0},
    // Emits whose index is out of range, then deletes, an out-of-range read and a clear.
    '{OP_EMIT_PRE, 7'd4,   8'h00, 1'b1, '{8'h00, 7'd3, 1'b0, 1'b1, 1'b1}},
    '{OP_EMIT_SUF, 7'd3,   8'h00, 1'b1, '{8'h00, 7'd3, 1'b0, 1'b1, 1'b1}},
    '{OP_DELETE,   7'd2,   8'h00, 1'b0, '0},
    '{OP_READ,     7'd127, 8'h00, 1'b1, '{8'h00, 7'd2, 1'b0, 1'b0, 1'b1}},
    '{OP_DELETE,   7'd0,   8'h00, 1'b0, '0},
    '{OP_EMIT_PRE, 7'd0,   8'h00, 1'b1, '{8'h00, 7'd1, 1'b1, 1'b1, 1'b1}},
    '{OP_CLEAR,    7'd99,  8'hFF, 1'b1, '{8'h00, 7'd0, 1'b1, 1'b0, 1'b1}}
  };

  fixed_capacity_char_sequence_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Streams the stored bytes in [from, to) as results, or one empty result when the
  // range holds nothing.
  function automatic void stream_slice(int from, int to, ref fcs_result_t replies[$]);
    fcs_result_t r;
    if (from >= to) begin
      replies.push_back('{8'h00, seq_count[6:0], 1'b1, 1'b1, 1'b1});
      return;
    end
    for (int i = from; i < to; i++) begin
      r = '{seq_mem[i], seq_count[6:0], 1'b1, 1'b0, (i + 1 == to)};
      replies.push_back(r);
    end
  endfunction

  // Applies one request to the behavioral sequence and lists the results it causes.
  task automatic compute_seq_replies(input fcs_op_t op, input logic [6:0] idx,
                                     input logic [7:0] val, ref fcs_result_t replies[$]);
    int  n;
    int  k;
    bit  ok;
    logic [7:0] rd;
    n  = seq_count;
    k  = int'(idx);
    ok = 1'b0;
    rd = 8'h00;
    case (op)
      OP_CLEAR: begin
        seq_count = 0;
        ok = 1'b1;
      end
      OP_APPEND: begin
        if (n < SEQ_CAP) begin
          seq_mem[n] = val;
          seq_count = n + 1;
          ok = 1'b1;
        end
      end
      OP_READ: begin
        if (k < n) begin
          rd = seq_mem[k];
          ok = 1'b1;
        end
      end
      OP_MODIFY: begin
        if (k < n) begin
          seq_mem[k] = val;
          ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (k < n) begin
          for (int i = k; i + 1 < n; i++) seq_mem[i] = seq_mem[i + 1];
          seq_count = n - 1;
          ok = 1'b1;
        end
      end
      OP_INSERT: begin
        // The slot at the count itself is not a legal insert position.
        if (n < SEQ_CAP && k < n) begin
          for (int i = n; i > k; i--) seq_mem[i] = seq_mem[i - 1];
          seq_mem[k] = val;
          seq_count = n + 1;
          ok = 1'b1;
        end
      end
      OP_EMIT_PRE: begin
        if (k <= n) stream_slice(0, k, replies);
        else replies.push_back('{8'h00, seq_count[6:0], 1'b0, 1'b1, 1'b1});
        return;
      end
      default: begin
        if (k < n) stream_slice(k + 1, n, replies);
        else replies.push_back('{8'h00, seq_count[6:0], 1'b0, 1'b1, 1'b1});
        return;
      end
    endcase
    replies.push_back('{rd, seq_count[6:0], ok, 1'b0, 1'b1});
  endtask

  // Offers one request after a random gap, waits for the handshake and then records
  // what the block owes for it. A typed row replaces the model's answer by its own.
  task automatic issue_request(fcs_op_t op, logic [6:0] idx, logic [7:0] val,
                               bit typed = 1'b0, fcs_result_t want = '0);
    int gap;
    fcs_result_t replies [$];
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (seq_count == SEQ_CAP) full_hits++;
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, val, idx, op};
    do @(posedge clk); while (!in_tready);
    compute_seq_replies(op, idx, val, replies);
    requests_sent++;
    if (!replies[replies.size() - 1].accepted) refused_seen++;
    if (replies.size() > max_stream) max_stream = replies.size();
    if (typed) seq_replies_due.push_back(want);
    else foreach (replies[i]) seq_replies_due.push_back(replies[i]);
  endtask

  // Stops offering until every owed result has come back, then lets a shift walk finish.
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (seq_replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random request shaped by the current count: most indexes are in range, some sit on
  // the count itself, and a few cover the whole 7-bit field.
  task automatic issue_random_request();
    int      r;
    fcs_op_t op;
    logic [6:0] idx;
    r = $urandom_range(0, 99);
    if      (r < 3)  op = OP_CLEAR;
    else if (r < 28) op = OP_APPEND;
    else if (r < 40) op = OP_READ;
    else if (r < 50) op = OP_MODIFY;
    else if (r < 62) op = OP_DELETE;
    else if (r < 78) op = OP_INSERT;
    else if (r < 89) op = OP_EMIT_PRE;
    else             op = OP_EMIT_SUF;
    r = $urandom_range(0, 99);
    if (r < 8)                         idx = 7'($urandom_range(0, 127));
    else if (r < 20 || seq_count == 0) idx = 7'(seq_count);
    else                               idx = 7'($urandom_range(0, seq_count - 1));
    issue_request(op, idx, 8'($urandom_range(0, 255)));
  endtask

  task automatic note_mismatch(string what, fcs_result_t want, fcs_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s) at %0t: want data=%02h len=%0d acc=%0b empty=%0b last=%0b",
               what, $time, want.data, want.length, want.accepted,
               want.empty_result, want.last);
      $display("  got data=%02h len=%0d acc=%0b empty=%0b last=%0b",
               got.data, got.length, got.accepted, got.empty_result, got.last);
    end
  endtask

  // Result checker. Signals are read right at the edge, so they hold the values of the
  // cycle that just ended, whatever order the processes of this step run in.
  always @(posedge clk) begin
    fcs_result_t got;
    fcs_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[7:0], out_tdata[14:8], out_tuser[0], out_tuser[1], out_tlast};
      results_seen++;
      if (seq_replies_due.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = seq_replies_due.pop_front();
        if (got !== want || out_tdata[15] !== 1'b0) note_mismatch("field", want, got);
      end
    end
  end

  // Receiver. It stalls at random at the current rate, and on request holds off for a
  // long stretch so that the block backs up and stops taking new requests.
  initial begin
    bit held;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles in which neither side moves a request or a result.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results still owed",
                 quiet_cycles, seq_replies_due.size());
        $display("fixed_capacity_char_sequence_top_tb failed");
        $finish;
      end
    end
  end

  initial begin
    int phase_items;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    stall_req     = 1'b0;
    seq_count     = 0;
    requests_sent = 0;
    refused_seen  = 0;
    full_hits     = 0;
    max_stream    = 0;
    // First setting: the sender idles about a third of the time, the receiver more.
    send_idle_pct = 34;
    recv_idle_pct = 64;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i])
      issue_request(stim_rows[i].op, stim_rows[i].idx, stim_rows[i].val,
                    stim_rows[i].typed, stim_rows[i].want);
    drain_replies();

    // Random requests; partway through, the receiver holds off for a long time while
    // the sender keeps offering.
    for (int i = 0; i < 80; i++) begin
      if (i == 30) stall_req = 1'b1;
      issue_random_request();
    end
    drain_replies();

    // Roles swapped. Fill the store to capacity, hit it with requests that need room,
    // stream it whole, and carry on at random from the full state.
    send_idle_pct = 64;
    recv_idle_pct = 34;
    issue_request(OP_CLEAR, 7'd0, 8'h00);
    phase_items = 1;
    while (seq_count < SEQ_CAP) begin
      issue_request(OP_APPEND, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
      phase_items++;
    end
    issue_request(OP_APPEND, 7'd0, 8'h5A);
    issue_request(OP_INSERT, 7'($urandom_range(0, SEQ_CAP - 1)), 8'hA5);
    issue_request(OP_EMIT_PRE, 7'(SEQ_CAP), 8'h00);
    issue_request(OP_EMIT_SUF, 7'd0, 8'h00);
    issue_request(OP_READ, 7'(SEQ_CAP - 1), 8'h00);
    phase_items += 5;
    while (phase_items < 100) begin
      issue_random_request();
      phase_items++;
    end
    drain_replies();

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 80; i++) issue_random_request();
    drain_replies();

    $display("covered %0d requests (%0d refused, %0d offered while full), %0d results checked",
             requests_sent, refused_seen, full_hits, results_seen);
    $display("longest stream %0d results; %0d mismatches", max_stream, mismatches);
    if (mismatches == 0) begin
      $display("fixed_capacity_char_sequence_top_tb passed");
    end else begin
      $display("fixed_capacity_char_sequence_top_tb failed");
    end
    $finish;
  end

endmodule
